FILE: hw/rtl/frlcd_pkg.sv
// Package for the fax run length code decoder: entry type, code sets and
// the one-dimensional Modified Huffman code list used by the code matcher.
// No dependencies.
package frlcd_pkg;

    localparam int CODE_W        = 13;
    localparam int LEN_W         = 4;
    localparam int RUN_W         = 12;
    localparam int ROW_W         = 14;
    localparam int MAX_ROW_WIDTH = 8192;
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 14'd1728;
    localparam logic [RUN_W-1:0] MAKEUP_MIN      = 12'd64;
    localparam int NUM_CODES     = 196;

    typedef enum logic [1:0] {
        SET_WHITE = 2'd0,
        SET_BLACK = 2'd1,
        SET_BOTH  = 2'd2,
        SET_EOL   = 2'd3
    } code_set_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EOL     = 2'd1,
        ST_INVALID = 2'd2,
        ST_OVER    = 2'd3
    } status_t;

    // Code bits are right aligned, first bit in the most significant used bit.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [RUN_W-1:0]  run;
        code_set_t         set;
    } code_entry_t;

    typedef struct packed {
        logic             alive;
        logic             hit;
        logic             eol;
        logic [RUN_W-1:0] run;
    } match_t;

    localparam code_entry_t MH_CODES [NUM_CODES] = '{
        '{4'd8,13'b00110101,12'd0,SET_WHITE},'{4'd6,13'b000111,12'd1,SET_WHITE},
        '{4'd4,13'b0111,12'd2,SET_WHITE},'{4'd4,13'b1000,12'd3,SET_WHITE},
        '{4'd4,13'b1011,12'd4,SET_WHITE},'{4'd4,13'b1100,12'd5,SET_WHITE},
        '{4'd4,13'b1110,12'd6,SET_WHITE},'{4'd4,13'b1111,12'd7,SET_WHITE},
        '{4'd5,13'b10011,12'd8,SET_WHITE},'{4'd5,13'b10100,12'd9,SET_WHITE},
        '{4'd5,13'b00111,12'd10,SET_WHITE},'{4'd5,13'b01000,12'd11,SET_WHITE},
        '{4'd6,13'b001000,12'd12,SET_WHITE},'{4'd6,13'b000011,12'd13,SET_WHITE},
        '{4'd6,13'b110100,12'd14,SET_WHITE},'{4'd6,13'b110101,12'd15,SET_WHITE},
        '{4'd6,13'b101010,12'd16,SET_WHITE},'{4'd6,13'b101011,12'd17,SET_WHITE},
        '{4'd7,13'b0100111,12'd18,SET_WHITE},'{4'd7,13'b0001100,12'd19,SET_WHITE},
        '{4'd7,13'b0001000,12'd20,SET_WHITE},'{4'd7,13'b0010111,12'd21,SET_WHITE},
        '{4'd7,13'b0000011,12'd22,SET_WHITE},'{4'd7,13'b0000100,12'd23,SET_WHITE},
        '{4'd7,13'b0101000,12'd24,SET_WHITE},'{4'd7,13'b0101011,12'd25,SET_WHITE},
        '{4'd7,13'b0010011,12'd26,SET_WHITE},'{4'd7,13'b0100100,12'd27,SET_WHITE},
        '{4'd7,13'b0011000,12'd28,SET_WHITE},'{4'd8,13'b00000010,12'd29,SET_WHITE},
        '{4'd8,13'b00000011,12'd30,SET_WHITE},'{4'd8,13'b00011010,12'd31,SET_WHITE},
        '{4'd8,13'b00011011,12'd32,SET_WHITE},'{4'd8,13'b00010010,12'd33,SET_WHITE},
        '{4'd8,13'b00010011,12'd34,SET_WHITE},'{4'd8,13'b00010100,12'd35,SET_WHITE},
        '{4'd8,13'b00010101,12'd36,SET_WHITE},'{4'd8,13'b00010110,12'd37,SET_WHITE},
        '{4'd8,13'b00010111,12'd38,SET_WHITE},'{4'd8,13'b00101000,12'd39,SET_WHITE},
        '{4'd8,13'b00101001,12'd40,SET_WHITE},'{4'd8,13'b00101010,12'd41,SET_WHITE},
        '{4'd8,13'b00101011,12'd42,SET_WHITE},'{4'd8,13'b00101100,12'd43,SET_WHITE},
        '{4'd8,13'b00101101,12'd44,SET_WHITE},'{4'd8,13'b00000100,12'd45,SET_WHITE},
        '{4'd8,13'b00000101,12'd46,SET_WHITE},'{4'd8,13'b00001010,12'd47,SET_WHITE},
        '{4'd8,13'b00001011,12'd48,SET_WHITE},'{4'd8,13'b01010010,12'd49,SET_WHITE},
        '{4'd8,13'b01010011,12'd50,SET_WHITE},'{4'd8,13'b01010100,12'd51,SET_WHITE},
        '{4'd8,13'b01010101,12'd52,SET_WHITE},'{4'd8,13'b00100100,12'd53,SET_WHITE},
        '{4'd8,13'b00100101,12'd54,SET_WHITE},'{4'd8,13'b01011000,12'd55,SET_WHITE},
        '{4'd8,13'b01011001,12'd56,SET_WHITE},'{4'd8,13'b01011010,12'd57,SET_WHITE},
        '{4'd8,13'b01011011,12'd58,SET_WHITE},'{4'd8,13'b01001010,12'd59,SET_WHITE},
        '{4'd8,13'b01001011,12'd60,SET_WHITE},'{4'd8,13'b00110010,12'd61,SET_WHITE},
        '{4'd8,13'b00110011,12'd62,SET_WHITE},'{4'd8,13'b00110100,12'd63,SET_WHITE},
        '{4'd5,13'b11011,12'd64,SET_WHITE},'{4'd5,13'b10010,12'd128,SET_WHITE},
        '{4'd6,13'b010111,12'd192,SET_WHITE},'{4'd7,13'b0110111,12'd256,SET_WHITE},
        '{4'd8,13'b00110110,12'd320,SET_WHITE},'{4'd8,13'b00110111,12'd384,SET_WHITE},
        '{4'd8,13'b01100100,12'd448,SET_WHITE},'{4'd8,13'b01100101,12'd512,SET_WHITE},
        '{4'd8,13'b01101000,12'd576,SET_WHITE},'{4'd8,13'b01100111,12'd640,SET_WHITE},
        '{4'd9,13'b011001100,12'd704,SET_WHITE},'{4'd9,13'b011001101,12'd768,SET_WHITE},
        '{4'd9,13'b011010010,12'd832,SET_WHITE},'{4'd9,13'b011010011,12'd896,SET_WHITE},
        '{4'd9,13'b011010100,12'd960,SET_WHITE},'{4'd9,13'b011010101,12'd1024,SET_WHITE},
        '{4'd9,13'b011010110,12'd1088,SET_WHITE},'{4'd9,13'b011010111,12'd1152,SET_WHITE},
        '{4'd9,13'b011011000,12'd1216,SET_WHITE},'{4'd9,13'b011011001,12'd1280,SET_WHITE},
        '{4'd9,13'b011011010,12'd1344,SET_WHITE},'{4'd9,13'b011011011,12'd1408,SET_WHITE},
        '{4'd9,13'b010011000,12'd1472,SET_WHITE},'{4'd9,13'b010011001,12'd1536,SET_WHITE},
        '{4'd9,13'b010011010,12'd1600,SET_WHITE},'{4'd6,13'b011000,12'd1664,SET_WHITE},
        '{4'd9,13'b010011011,12'd1728,SET_WHITE},
        '{4'd10,13'b0000110111,12'd0,SET_BLACK},'{4'd3,13'b010,12'd1,SET_BLACK},
        '{4'd2,13'b11,12'd2,SET_BLACK},'{4'd2,13'b10,12'd3,SET_BLACK},
        '{4'd3,13'b011,12'd4,SET_BLACK},'{4'd4,13'b0011,12'd5,SET_BLACK},
        '{4'd4,13'b0010,12'd6,SET_BLACK},'{4'd5,13'b00011,12'd7,SET_BLACK},
        '{4'd6,13'b000101,12'd8,SET_BLACK},'{4'd6,13'b000100,12'd9,SET_BLACK},
        '{4'd7,13'b0000100,12'd10,SET_BLACK},'{4'd7,13'b0000101,12'd11,SET_BLACK},
        '{4'd7,13'b0000111,12'd12,SET_BLACK},'{4'd8,13'b00000100,12'd13,SET_BLACK},
        '{4'd8,13'b00000111,12'd14,SET_BLACK},'{4'd9,13'b000011000,12'd15,SET_BLACK},
        '{4'd10,13'b0000010111,12'd16,SET_BLACK},'{4'd10,13'b0000011000,12'd17,SET_BLACK},
        '{4'd10,13'b0000001000,12'd18,SET_BLACK},'{4'd11,13'b00001100111,12'd19,SET_BLACK},
        '{4'd11,13'b00001101000,12'd20,SET_BLACK},'{4'd11,13'b00001101100,12'd21,SET_BLACK},
        '{4'd11,13'b00000110111,12'd22,SET_BLACK},'{4'd11,13'b00000101000,12'd23,SET_BLACK},
        '{4'd11,13'b00000010111,12'd24,SET_BLACK},'{4'd11,13'b00000011000,12'd25,SET_BLACK},
        '{4'd12,13'b000011001010,12'd26,SET_BLACK},'{4'd12,13'b000011001011,12'd27,SET_BLACK},
        '{4'd12,13'b000011001100,12'd28,SET_BLACK},'{4'd12,13'b000011001101,12'd29,SET_BLACK},
        '{4'd12,13'b000001101000,12'd30,SET_BLACK},'{4'd12,13'b000001101001,12'd31,SET_BLACK},
        '{4'd12,13'b000001101010,12'd32,SET_BLACK},'{4'd12,13'b000001101011,12'd33,SET_BLACK},
        '{4'd12,13'b000011010010,12'd34,SET_BLACK},'{4'd12,13'b000011010011,12'd35,SET_BLACK},
        '{4'd12,13'b000011010100,12'd36,SET_BLACK},'{4'd12,13'b000011010101,12'd37,SET_BLACK},
        '{4'd12,13'b000011010110,12'd38,SET_BLACK},'{4'd12,13'b000011010111,12'd39,SET_BLACK},
        '{4'd12,13'b000001101100,12'd40,SET_BLACK},'{4'd12,13'b000001101101,12'd41,SET_BLACK},
        '{4'd12,13'b000011011010,12'd42,SET_BLACK},'{4'd12,13'b000011011011,12'd43,SET_BLACK},
        '{4'd12,13'b000001010100,12'd44,SET_BLACK},'{4'd12,13'b000001010101,12'd45,SET_BLACK},
        '{4'd12,13'b000001010110,12'd46,SET_BLACK},'{4'd12,13'b000001010111,12'd47,SET_BLACK},
        '{4'd12,13'b000001100100,12'd48,SET_BLACK},'{4'd12,13'b000001100101,12'd49,SET_BLACK},
        '{4'd12,13'b000001010010,12'd50,SET_BLACK},'{4'd12,13'b000001010011,12'd51,SET_BLACK},
        '{4'd12,13'b000000100100,12'd52,SET_BLACK},'{4'd12,13'b000000110111,12'd53,SET_BLACK},
        '{4'd12,13'b000000111000,12'd54,SET_BLACK},'{4'd12,13'b000000100111,12'd55,SET_BLACK},
        '{4'd12,13'b000000101000,12'd56,SET_BLACK},'{4'd12,13'b000001011000,12'd57,SET_BLACK},
        '{4'd12,13'b000001011001,12'd58,SET_BLACK},'{4'd12,13'b000000101011,12'd59,SET_BLACK},
        '{4'd12,13'b000000101100,12'd60,SET_BLACK},'{4'd12,13'b000001011010,12'd61,SET_BLACK},
        '{4'd12,13'b000001100110,12'd62,SET_BLACK},'{4'd12,13'b000001100111,12'd63,SET_BLACK},
        '{4'd10,13'b0000001111,12'd64,SET_BLACK},'{4'd12,13'b000011001000,12'd128,SET_BLACK},
        '{4'd12,13'b000011001001,12'd192,SET_BLACK},'{4'd12,13'b000001011011,12'd256,SET_BLACK},
        '{4'd12,13'b000000110011,12'd320,SET_BLACK},'{4'd12,13'b000000110100,12'd384,SET_BLACK},
        '{4'd12,13'b000000110101,12'd448,SET_BLACK},'{4'd13,13'b0000001101100,12'd512,SET_BLACK},
        '{4'd13,13'b0000001101101,12'd576,SET_BLACK},'{4'd13,13'b0000001001010,12'd640,SET_BLACK},
        '{4'd13,13'b0000001001011,12'd704,SET_BLACK},'{4'd13,13'b0000001001100,12'd768,SET_BLACK},
        '{4'd13,13'b0000001001101,12'd832,SET_BLACK},'{4'd13,13'b0000001110010,12'd896,SET_BLACK},
        '{4'd13,13'b0000001110011,12'd960,SET_BLACK},'{4'd13,13'b0000001110100,12'd1024,SET_BLACK},
        '{4'd13,13'b0000001110101,12'd1088,SET_BLACK},'{4'd13,13'b0000001110110,12'd1152,SET_BLACK},
        '{4'd13,13'b0000001110111,12'd1216,SET_BLACK},'{4'd13,13'b0000001010010,12'd1280,SET_BLACK},
        '{4'd13,13'b0000001010011,12'd1344,SET_BLACK},'{4'd13,13'b0000001010100,12'd1408,SET_BLACK},
        '{4'd13,13'b0000001010101,12'd1472,SET_BLACK},'{4'd13,13'b0000001011010,12'd1536,SET_BLACK},
        '{4'd13,13'b0000001011011,12'd1600,SET_BLACK},'{4'd13,13'b0000001100100,12'd1664,SET_BLACK},
        '{4'd13,13'b0000001100101,12'd1728,SET_BLACK},
        '{4'd11,13'b00000001000,12'd1792,SET_BOTH},'{4'd11,13'b00000001100,12'd1856,SET_BOTH},
        '{4'd11,13'b00000001101,12'd1920,SET_BOTH},'{4'd12,13'b000000010010,12'd1984,SET_BOTH},
        '{4'd12,13'b000000010011,12'd2048,SET_BOTH},'{4'd12,13'b000000010100,12'd2112,SET_BOTH},
        '{4'd12,13'b000000010101,12'd2176,SET_BOTH},'{4'd12,13'b000000010110,12'd2240,SET_BOTH},
        '{4'd12,13'b000000010111,12'd2304,SET_BOTH},'{4'd12,13'b000000011100,12'd2368,SET_BOTH},
        '{4'd12,13'b000000011101,12'd2432,SET_BOTH},'{4'd12,13'b000000011110,12'd2496,SET_BOTH},
        '{4'd12,13'b000000011111,12'd2560,SET_BOTH},
        '{4'd12,13'b000000000001,12'd0,SET_EOL}
    };

endpackage

FILE: hw/rtl/frlcd_match.sv
// Code matcher: compares the current prefix against every code of the active
// color and the shared codes. Depends on frlcd_pkg.
module frlcd_match
    import frlcd_pkg::*;
(
    input  logic              color,
    input  logic [CODE_W-1:0] prefix,
    input  logic [LEN_W-1:0]  len,
    output match_t            result
);

    always_comb begin
        logic [CODE_W-1:0] pre_la;
        logic [CODE_W-1:0] code_la;
        logic [CODE_W-1:0] mask;
        result = '0;
        // Left-align the prefix and keep only its top len bits for compare.
        pre_la = prefix << (LEN_W'(CODE_W) - len);
        mask   = ~({CODE_W{1'b1}} >> len);
        for (int i = 0; i < NUM_CODES; i++) begin
            code_la = MH_CODES[i].code << (LEN_W'(CODE_W) - MH_CODES[i].len);
            if ((MH_CODES[i].set == SET_BOTH || MH_CODES[i].set == SET_EOL ||
                 MH_CODES[i].set == code_set_t'({1'b0, color})) &&
                MH_CODES[i].len >= len && ((code_la ^ pre_la) & mask) == '0) begin
                result.alive = 1'b1;
                if (MH_CODES[i].len == len) begin
                    result.hit = 1'b1;
                    result.eol = (MH_CODES[i].set == SET_EOL);
                    result.run = MH_CODES[i].run;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/fax_run_length_code_decoder.sv
// Top level of the fax run length code decoder: row state, code prefix,
// row accounting and the result register. Depends on frlcd_pkg, frlcd_match.
//
// Usage: the input channel (s_) carries one beat per coded bit. s_tdata[0]
// is the code bit; s_tuser[0] is the mode, where 1 starts a new row (white,
// total cleared) and the code bit is ignored. The result channel (m_)
// carries one beat for every completed code, EOL or invalid prefix:
// m_tdata holds the run length, color and makeup flag, m_tuser the status
// and m_tlast marks the beat that closed the row.
// The user must write the row width on the cfg_ channel only while idle;
// the block does not enforce it. It is taken saturated to MAX_ROW_WIDTH,
// and zero counts as one. Every accepted bit is decoded in the cycle it
// is taken; a result appears on m_ in the cycle after the bit that
// completed the code. One bit is accepted per cycle, limited only by the
// single output register: s_tready is high whenever the output register is
// empty or is being read. When the receiver stalls, a waiting result holds
// and the input stalls with it. Reset clears the prefix, the color (white),
// the row total and the output valid, and sets the row width to 1728.
module fax_run_length_code_decoder
    import frlcd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH_P = MAX_ROW_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ROW_W-1:0] cfg_data,   // row_width
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] code_bit, [7:1] zero
    input  logic [0:0]       s_tuser,    // [0] mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [11:0] run_length, [12] is_black,
                                         // [13] is_makeup, [15:14] zero
    output logic [1:0]       m_tuser,    // [1:0] status
    output logic             m_tlast     // row_end
);

    // Any written width and the row total plus the longest run must fit.
    localparam int WIDTH_CAP = (MAX_ROW_WIDTH_P > (1 << ROW_W) - 1) ? MAX_ROW_WIDTH_P
                                                                     : (1 << ROW_W) - 1;
    localparam int TOT_W = $clog2(WIDTH_CAP + 2561);
    localparam logic [TOT_W-1:0] MAX_W = TOT_W'(MAX_ROW_WIDTH_P);

    logic [ROW_W-1:0]  row_width_reg;
    logic              color_reg, color_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              m_valid_reg, m_valid_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              black_reg, black_next;
    logic              makeup_reg, makeup_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              accept;
    logic [CODE_W-1:0] cand_prefix;
    logic [LEN_W-1:0]  cand_len;
    logic [TOT_W-1:0]  width_eff;
    logic [TOT_W-1:0]  sum;
    match_t            match;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // A prefix that already holds the longest code length starts over.
    always_comb begin
        if (len_reg >= LEN_W'(CODE_W)) begin
            cand_prefix = {{(CODE_W-1){1'b0}}, s_tdata[0]};
            cand_len    = LEN_W'(1);
        end else begin
            cand_prefix = {prefix_reg[CODE_W-2:0], s_tdata[0]};
            cand_len    = len_reg + LEN_W'(1);
        end
    end

    frlcd_match u_match (
        .color  (color_reg),
        .prefix (cand_prefix),
        .len    (cand_len),
        .result (match)
    );

    always_comb begin
        width_eff = TOT_W'(row_width_reg);
        if (width_eff > MAX_W) begin
            width_eff = MAX_W;
        end
        if (width_eff == '0) begin
            width_eff = TOT_W'(1);
        end
        sum = total_reg + TOT_W'(match.run);
    end

    always_comb begin
        color_next   = color_reg;
        prefix_next  = prefix_reg;
        len_next     = len_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        run_next     = run_reg;
        black_next   = black_reg;
        makeup_next  = makeup_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        if (accept) begin
            if (s_tuser[0]) begin
                color_next  = 1'b0;
                prefix_next = '0;
                len_next    = '0;
                total_next  = '0;
            end else if (!match.hit && match.alive) begin
                prefix_next = cand_prefix;
                len_next    = cand_len;
            end else begin
                prefix_next  = '0;
                len_next     = '0;
                m_valid_next = 1'b1;
                black_next   = color_reg;
                run_next     = '0;
                makeup_next  = 1'b0;
                last_next    = 1'b0;
                if (!match.hit) begin
                    status_next = ST_INVALID;
                end else if (match.eol) begin
                    status_next = ST_EOL;
                    color_next  = 1'b0;
                    total_next  = '0;
                end else begin
                    run_next    = match.run;
                    makeup_next = (match.run >= MAKEUP_MIN);
                    status_next = ST_OK;
                    // A terminating code hands over to the other color.
                    color_next  = (match.run >= MAKEUP_MIN) ? color_reg : !color_reg;
                    if (sum >= width_eff) begin
                        last_next   = 1'b1;
                        status_next = (sum > width_eff) ? ST_OVER : ST_OK;
                        color_next  = 1'b0;
                        total_next  = '0;
                    end else begin
                        total_next = sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
            color_reg     <= 1'b0;
            prefix_reg    <= '0;
            len_reg       <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                row_width_reg <= cfg_data;
            end
            color_reg   <= color_next;
            prefix_reg  <= prefix_next;
            len_reg     <= len_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg    <= run_next;
        black_reg  <= black_next;
        makeup_reg <= makeup_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, makeup_reg, black_reg, run_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: verif/tb_fax_run_length_code_decoder.sv
// Self-checking testbench for the fax run length code decoder: codes bit
// streams, predicts decoded runs, statuses and row ends, and checks them.
// Depends on frlcd_pkg and the fax_run_length_code_decoder RTL.
module tb_fax_run_length_code_decoder;
    import frlcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input beat: the mode flag and the coded bit.
    typedef struct packed {
        logic mode;
        logic bit_in;
    } bit_beat_t;

    // One decoded result as the block reports it.
    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic             black;
        logic             makeup;
        status_t          status;
        logic             row_end;
    } run_result_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [ROW_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;    // [0] code_bit, [7:1] zero
    logic [0:0]       s_tuser;    // [0] mode
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;    // [11:0] run_length, [12] is_black, [13] is_makeup
    logic [1:0]       m_tuser;    // [1:0] status
    logic             m_tlast;    // row_end

    fax_run_length_code_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Code list of our own, one entry per table line: bit string, run, set.
    typedef struct {
        string     bits;
        int        run;
        code_set_t set;
    } mh_word_t;

    mh_word_t mh_words[$];

    // Predictor state, mirroring the decoder's row state.
    logic [ROW_W-1:0]  width_reg;
    logic              color;
    logic [CODE_W-1:0] prefix;
    int                prefix_len;
    int                row_sum;

    bit_beat_t   pending_bits[$];
    run_result_t expected_runs[$];
    int          error_count;
    int          result_count;
    int          status_seen[4];
    int          rows_ended;
    bit          hold_sink;
    bit          sink_released;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic void add_word(string b, int r, code_set_t s);
        mh_word_t w;
        w.bits = b;
        w.run  = r;
        w.set  = s;
        mh_words.push_back(w);
    endfunction

    // Build the code list; white and black terminating and makeup codes come
    // first, then the shared extended makeup codes and the EOL word.
    task automatic build_words();
        string wt[64];
        string wm[27];
        string bt[64];
        string bm[27];
        string ext[13];
        wt = '{"00110101","000111","0111","1000","1011","1100","1110","1111",
               "10011","10100","00111","01000","001000","000011","110100","110101",
               "101010","101011","0100111","0001100","0001000","0010111","0000011",
               "0000100","0101000","0101011","0010011","0100100","0011000","00000010",
               "00000011","00011010","00011011","00010010","00010011","00010100",
               "00010101","00010110","00010111","00101000","00101001","00101010",
               "00101011","00101100","00101101","00000100","00000101","00001010",
               "00001011","01010010","01010011","01010100","01010101","00100100",
               "00100101","01011000","01011001","01011010","01011011","01001010",
               "01001011","00110010","00110011","00110100"};
        wm = '{"11011","10010","010111","0110111","00110110","00110111","01100100",
               "01100101","01101000","01100111","011001100","011001101","011010010",
               "011010011","011010100","011010101","011010110","011010111",
               "011011000","011011001","011011010","011011011","010011000",
               "010011001","010011010","011000","010011011"};
        bt = '{"0000110111","010","11","10","011","0011","0010","00011","000101",
               "000100","0000100","0000101","0000111","00000100","00000111",
               "000011000","0000010111","0000011000","0000001000","00001100111",
               "00001101000","00001101100","00000110111","00000101000","00000010111",
               "00000011000","000011001010","000011001011","000011001100",
               "000011001101","000001101000","000001101001","000001101010",
               "000001101011","000011010010","000011010011","000011010100",
               "000011010101","000011010110","000011010111","000001101100",
               "000001101101","000011011010","000011011011","000001010100",
               "000001010101","000001010110","000001010111","000001100100",
               "000001100101","000001010010","000001010011","000000100100",
               "000000110111","000000111000","000000100111","000000101000",
               "000001011000","000001011001","000000101011","000000101100",
               "000001011010","000001100110","000001100111"};
        bm = '{"0000001111","000011001000","000011001001","000001011011",
               "000000110011","000000110100","000000110101","0000001101100",
               "0000001101101","0000001001010","0000001001011","0000001001100",
               "0000001001101","0000001110010","0000001110011","0000001110100",
               "0000001110101","0000001110110","0000001110111","0000001010010",
               "0000001010011","0000001010100","0000001010101","0000001011010",
               "0000001011011","0000001100100","0000001100101"};
        ext = '{"00000001000","00000001100","00000001101","000000010010",
                "000000010011","000000010100","000000010101","000000010110",
                "000000010111","000000011100","000000011101","000000011110",
                "000000011111"};
        for (int i = 0; i < 64; i++) add_word(wt[i], i, SET_WHITE);
        for (int i = 0; i < 27; i++) add_word(wm[i], 64 * (i + 1), SET_WHITE);
        for (int i = 0; i < 64; i++) add_word(bt[i], i, SET_BLACK);
        for (int i = 0; i < 27; i++) add_word(bm[i], 64 * (i + 1), SET_BLACK);
        for (int i = 0; i < 13; i++) add_word(ext[i], 1792 + 64 * i, SET_BOTH);
        add_word("000000000001", 0, SET_EOL);
    endtask

    function automatic void start_row();
        color      = 1'b0;
        row_sum    = 0;
        prefix     = '0;
        prefix_len = 0;
    endfunction

    // Decode one accepted beat and queue the result it completes, if any.
    function automatic void decode_bit(bit_beat_t b);
        int          hit;
        bit          alive;
        int          n;
        bit          same;
        int          lim;
        int          total;
        run_result_t r;
        hit   = -1;
        alive = 0;
        if (b.mode) begin
            start_row();
            return;
        end
        if (prefix_len >= 13) begin
            prefix     = '0;
            prefix_len = 0;
        end
        prefix = {prefix[CODE_W-2:0], b.bit_in};
        prefix_len++;
        foreach (mh_words[i]) begin
            if (mh_words[i].set == SET_WHITE && color) continue;
            if (mh_words[i].set == SET_BLACK && !color) continue;
            n = mh_words[i].bits.len();
            if (n < prefix_len) continue;
            same = 1;
            for (int k = 0; k < prefix_len; k++)
                if ((mh_words[i].bits[k] == "1") != prefix[prefix_len - 1 - k]) same = 0;
            if (!same) continue;
            alive = 1;
            if (n == prefix_len) hit = i;
        end
        if (hit < 0 && alive) return;
        prefix     = '0;
        prefix_len = 0;
        r.run     = '0;
        r.black   = color;
        r.makeup  = 1'b0;
        r.row_end = 1'b0;
        if (hit < 0) begin
            r.status = ST_INVALID;
        end else if (mh_words[hit].set == SET_EOL) begin
            r.status = ST_EOL;
            start_row();
        end else begin
            r.run    = RUN_W'(mh_words[hit].run);
            r.makeup = mh_words[hit].run >= 64;
            r.status = ST_OK;
            if (!r.makeup) color = ~color;
            lim = width_reg > MAX_ROW_WIDTH ? MAX_ROW_WIDTH : width_reg;
            if (lim == 0) lim = 1;
            total = row_sum + mh_words[hit].run;
            if (total >= lim) begin
                r.row_end = 1'b1;
                r.status  = total > lim ? ST_OVER : ST_OK;
                start_row();
            end else begin
                row_sum = total;
            end
        end
        expected_runs.push_back(r);
    endfunction

    // Queue the bits of one code word, first bit first.
    function automatic void queue_word(int idx);
        bit_beat_t b;
        for (int k = 0; k < mh_words[idx].bits.len(); k++) begin
            b.mode   = 1'b0;
            b.bit_in = mh_words[idx].bits[k] == "1";
            pending_bits.push_back(b);
        end
    endfunction

    function automatic void queue_raw(bit m, bit v);
        bit_beat_t b;
        b.mode   = m;
        b.bit_in = v;
        pending_bits.push_back(b);
    endfunction

    // Queue a random code word of the given color, usually a terminating code.
    // Returns 1 when the word switches the color.
    function automatic bit queue_random_word(bit black);
        int base;
        int pick;
        base = black ? 91 : 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            queue_word(base + $urandom_range(0, 63));
            return 1;
        end else if (pick < 92) begin
            queue_word(base + 64 + $urandom_range(0, 26));
        end else begin
            queue_word(182 + $urandom_range(0, 12));
        end
        return 0;
    endfunction

    // Driver: offers queued beats with random gaps, most of them short.
    // The beat on offer is always the front of the queue until it is taken.
    int src_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) decode_bit(pending_bits.pop_front());
            if (s_tvalid && !s_tready) begin
                // The beat stays on offer until it is taken.
            end else if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (pending_bits.size() > 0) begin
                bit_beat_t nb;
                nb = pending_bits[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, nb.bit_in};
                s_tuser  <= nb.mode;
                if ($urandom_range(0, 3) == 0)
                    src_gap <= $urandom_range(0, 9) == 0 ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 2);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    int sink_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                run_result_t e;
                result_count++;
                if (expected_runs.size() == 0) begin
                    $error("result beat with nothing expected: tdata=%h", m_tdata);
                    error_count++;
                end else begin
                    e = expected_runs.pop_front();
                    status_seen[e.status]++;
                    if (e.row_end) rows_ended++;
                    if (m_tdata[11:0] !== e.run) begin
                        $error("run_length expected %0d got %0d", e.run, m_tdata[11:0]);
                        error_count++;
                    end
                    if (m_tdata[12] !== e.black) begin
                        $error("is_black expected %0b got %0b", e.black, m_tdata[12]);
                        error_count++;
                    end
                    if (m_tdata[13] !== e.makeup) begin
                        $error("is_makeup expected %0b got %0b", e.makeup, m_tdata[13]);
                        error_count++;
                    end
                    if (m_tuser !== e.status) begin
                        $error("status expected %0d got %0d", e.status, m_tuser);
                        error_count++;
                    end
                    if (m_tlast !== e.row_end) begin
                        $error("row_end expected %0b got %0b", e.row_end, m_tlast);
                        error_count++;
                    end
                end
            end
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    sink_gap <= $urandom_range(0, 9) == 0 ? $urandom_range(8, 30)
                                                          : $urandom_range(1, 2);
            end
        end
    end

    // Long receiver stall counted in cycles while the sender keeps offering.
    initial begin
        hold_sink     = 1'b0;
        sink_released = 1'b0;
        wait (result_count >= 40);
        @(posedge aclk);
        hold_sink = 1'b1;
        repeat (300) @(posedge aclk);
        hold_sink     = 1'b0;
        sink_released = 1'b1;
    end

    task automatic wait_drained();
        while (pending_bits.size() != 0 || expected_runs.size() != 0)
            @(posedge aclk);
        // A partial prefix leaves no result behind, so let the pipe settle.
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_width(logic [ROW_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // Random rows: mostly well-formed code sequences, some noise and EOLs.
    task automatic random_phase(int beats);
        bit black;
        black = 0;
        while (pending_bits.size() < beats) begin
            case ($urandom_range(0, 19))
                0:       begin queue_raw(1'b1, 1'($urandom_range(0, 1))); black = 0; end
                1:       begin queue_word(195); black = 0; end
                2:       for (int k = $urandom_range(1, 14); k > 0; k--)
                             queue_raw(1'b0, 1'($urandom_range(0, 1)));
                default: if (queue_random_word(black)) black = ~black;
            endcase
        end
        // Close with a new-row beat so the expected color tracking resyncs.
        queue_raw(1'b1, 1'b0);
    endtask

    initial begin
        logic [ROW_W-1:0] widths[5];
        error_count  = 0;
        result_count = 0;
        rows_ended   = 0;
        status_seen  = '{0, 0, 0, 0};
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        width_reg    = ROW_WIDTH_RESET;
        start_row();
        build_words();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: shortest and longest codes, makeup, extended, EOL, a
        // new row mid-prefix, twelve zeros, and a row that exactly fills.
        queue_word(2);              // white 2
        queue_word(93);             // black 2 (two-bit code)
        queue_word(63);             // white 63
        queue_word(91 + 64 + 26);   // black 1728 (13-bit makeup)
        queue_word(194);            // extended 2560 ends the row
        queue_raw(1'b0, 1'b0);
        queue_raw(1'b1, 1'b1);      // new row abandons the prefix
        queue_word(195);            // EOL
        for (int k = 0; k < 12; k++) queue_raw(1'b0, 1'b0);
        queue_word(90);             // white 1728 fills the default row exactly
        wait_drained();

        widths = '{14'd1, 14'd0, 14'd16383, 14'd8192, 14'd100};
        for (int p = 0; p < 5; p++) begin
            write_width(widths[p]);
            queue_raw(1'b1, 1'b0);
            start_row();
            random_phase(p == 4 ? 200 : 120);
            wait_drained();
        end

        wait (sink_released);
        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Checked %0d results: %0d ok, %0d EOL, %0d invalid, %0d over width.",
                 result_count, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("%0d rows closed across six row widths including 0, 1 and the maximum.",
                 rows_ended);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
